[src/polled_quadrature_tuning_knob_unit_defines.svh]
// Assertion helpers for the tuning knob unit.
`ifndef POLLED_QUADRATURE_TUNING_KNOB_UNIT_DEFINES_SVH
`define POLLED_QUADRATURE_TUNING_KNOB_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PQTK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PQTK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/pqtk_pkg.sv]
package pqtk_pkg;

    // field widths
    localparam int STEP_SIZE_W = 14;
    localparam int TIMER_W     = 16;
    localparam int TRIGGER_W   = 8;
    localparam int GAIN_W      = 7;
    localparam int MAG_W       = STEP_SIZE_W + GAIN_W;
    localparam int DELTA_W     = 22;
    localparam int FREQ_W      = 32;
    localparam int DIR_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_TRIGGER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ENABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_SENSE      = 3'd6;

    // register reset values
    localparam logic [STEP_SIZE_W-1:0] RST_STEP_SIZE      = 14'd8388;
    localparam logic [TIMER_W-1:0]     RST_FAST_THRESHOLD = 16'd3000;
    localparam logic [TRIGGER_W-1:0]   RST_FAST_TRIGGER   = 8'd10;
    localparam logic [GAIN_W-1:0]      RST_FAST_GAIN      = 7'd10;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd3;

    localparam logic [TRIGGER_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [STEP_SIZE_W-1:0] step_size;
        logic [TIMER_W-1:0]     fast_threshold;
        logic [TRIGGER_W-1:0]   fast_trigger;
        logic [GAIN_W-1:0]      fast_gain;
        logic                   reverse_dir;
        logic                   accel_enable;
        logic                   dir_sense_enable;
    } t_cfg;

    typedef struct packed {
        logic               phase_a;
        logic               phase_b;
        logic [TIMER_W-1:0] timer_now;
    } t_item;

    typedef struct packed {
        logic signed [DELTA_W-1:0] freq_delta;
        logic [FREQ_W-1:0]         frequency;
        logic                      freq_changed;
        logic                      fast_mode;
    } t_result;

endpackage

[src/pqtk_cfg_regs.sv]
module pqtk_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [pqtk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pqtk_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output pqtk_pkg::t_cfg                      o_cfg
);
    import pqtk_pkg::*;

    t_cfg r_cfg;

    // register file, writes masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size        <= RST_STEP_SIZE;
            r_cfg.fast_threshold   <= RST_FAST_THRESHOLD;
            r_cfg.fast_trigger     <= RST_FAST_TRIGGER;
            r_cfg.fast_gain        <= RST_FAST_GAIN;
            r_cfg.reverse_dir      <= 1'b0;
            r_cfg.accel_enable     <= 1'b1;
            r_cfg.dir_sense_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STEP_SIZE:      r_cfg.step_size      <= i_cfg_wdata[STEP_SIZE_W-1:0];
                REG_FAST_THRESHOLD: r_cfg.fast_threshold <= i_cfg_wdata[TIMER_W-1:0];
                REG_FAST_TRIGGER:   r_cfg.fast_trigger   <= i_cfg_wdata[TRIGGER_W-1:0];
                REG_FAST_GAIN:      r_cfg.fast_gain      <= i_cfg_wdata[GAIN_W-1:0];
                REG_REVERSE_DIR:    r_cfg.reverse_dir    <= i_cfg_wdata[0];
                REG_ACCEL_ENABLE:   r_cfg.accel_enable   <= i_cfg_wdata[0];
                REG_DIR_SENSE:      r_cfg.dir_sense_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/pqtk_core.sv]
`include "polled_quadrature_tuning_knob_unit_defines.svh"

module pqtk_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  pqtk_pkg::t_item   i_item,
    input  pqtk_pkg::t_cfg    i_cfg,
    output pqtk_pkg::t_result o_result
);
    import pqtk_pkg::*;

    // knob state
    logic                 r_prev_a, r_prev_b;
    logic [TIMER_W-1:0]   r_last_step_time;
    logic [TRIGGER_W-1:0] r_fast_count;
    logic [DIR_W-1:0]     r_last_direction;
    logic                 r_fast_flag;
    logic                 r_reversal_pending;
    logic [FREQ_W-1:0]    r_freq_accum;

    logic                 n_prev_a, n_prev_b;
    logic [TRIGGER_W-1:0] n_fast_count;
    logic [DIR_W-1:0]     n_last_direction;
    logic                 n_fast_flag;
    logic                 n_reversal_pending;
    logic [FREQ_W-1:0]    n_freq_accum;

    logic                 a_chg, b_chg, step, up, do_step, do_accel;
    logic                 rollover, fast_step;
    logic [TIMER_W-1:0]   elapsed;
    logic [DIR_W-1:0]     dcode;
    logic [GAIN_W-1:0]    mult;
    logic [MAG_W-1:0]     mag;
    logic                 neg;
    logic [DELTA_W-1:0]   delta;

    // step decode: exactly one phase changed
    always_comb begin
        a_chg    = i_item.phase_a != r_prev_a;
        b_chg    = i_item.phase_b != r_prev_b;
        step     = a_chg ^ b_chg;
        up       = a_chg ? (i_item.phase_a != r_prev_b) : (r_prev_a == i_item.phase_b);
        do_step  = i_en && step;
        do_accel = do_step && i_cfg.accel_enable;
        n_prev_a = (do_step && a_chg) ? i_item.phase_a : r_prev_a;
        n_prev_b = (do_step && b_chg) ? i_item.phase_b : r_prev_b;
    end

    // step timing and fast count (saturating, held across timer rollover)
    always_comb begin
        rollover  = r_last_step_time > i_item.timer_now;
        elapsed   = i_item.timer_now - r_last_step_time;
        fast_step = elapsed <= i_cfg.fast_threshold;
        priority if (rollover) begin
            n_fast_count = r_fast_count;
        end else if (fast_step) begin
            n_fast_count = (r_fast_count == COUNT_MAX) ? r_fast_count
                                                       : r_fast_count + 1'b1;
        end else begin
            n_fast_count = '0;
        end
    end

    // fast mode entry and reversal sense
    always_comb begin
        dcode              = up ? DIR_UP : DIR_DOWN;
        n_fast_flag        = r_fast_flag || (n_fast_count > i_cfg.fast_trigger);
        n_reversal_pending = r_reversal_pending;
        n_last_direction   = r_last_direction;
        if (i_cfg.dir_sense_enable) begin
            n_last_direction = dcode;
            if (r_last_direction != dcode) begin
                n_reversal_pending = !r_reversal_pending;
            end else if (r_reversal_pending) begin
                n_fast_flag        = 1'b0;
                n_reversal_pending = 1'b0;
            end
        end
    end

    // scaled, signed step and frequency update
    always_comb begin
        mult  = (i_cfg.accel_enable && n_fast_flag) ? i_cfg.fast_gain : GAIN_W'(1);
        mag   = MAG_W'(mult) * MAG_W'(i_cfg.step_size);
        neg   = up ? i_cfg.reverse_dir : !i_cfg.reverse_dir;
        delta = neg ? (DELTA_W'(0) - DELTA_W'(mag)) : DELTA_W'(mag);
        n_freq_accum = r_freq_accum + {{(FREQ_W-DELTA_W){delta[DELTA_W-1]}}, delta};
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a           <= 1'b0;
            r_prev_b           <= 1'b0;
            r_last_step_time   <= '0;
            r_fast_count       <= '0;
            r_last_direction   <= DIR_NONE;
            r_fast_flag        <= 1'b0;
            r_reversal_pending <= 1'b0;
            r_freq_accum       <= '0;
        end else begin
            r_prev_a <= n_prev_a;
            r_prev_b <= n_prev_b;
            if (do_step) begin
                r_freq_accum <= n_freq_accum;
            end
            if (do_accel) begin
                r_last_step_time   <= i_item.timer_now;
                r_fast_count       <= n_fast_count;
                r_last_direction   <= n_last_direction;
                r_fast_flag        <= n_fast_flag;
                r_reversal_pending <= n_reversal_pending;
            end
        end
    end

    // result of this poll, as it stands after the update
    always_comb begin
        o_result.freq_delta   = step ? delta : '0;
        o_result.frequency    = step ? n_freq_accum : r_freq_accum;
        o_result.freq_changed = step;
        o_result.fast_mode    = (do_accel ? n_fast_flag : r_fast_flag) && i_cfg.accel_enable;
    end

    `PQTK_ASSERT_NEXT(a_accum_hold, i_clk, i_rst_n, !do_step, $stable(r_freq_accum), "frequency moved without a step")
    `PQTK_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, !do_step, $stable({r_prev_a, r_prev_b}), "phases stored without a step")
    `PQTK_ASSERT_SAME(a_flag_rise, i_clk, i_rst_n, $rose(r_fast_flag), $past(do_accel), "fast mode entered without an accelerated step")
    `PQTK_ASSERT_NEXT(a_count_sat, i_clk, i_rst_n, do_accel && (r_fast_count == COUNT_MAX) && !rollover && fast_step, r_fast_count == COUNT_MAX, "fast count wrapped")

endmodule

[src/polled_quadrature_tuning_knob_unit.sv]
// Polled quadrature tuning knob: each accepted poll carries the encoder phase levels and a
// free-running timer value and gives exactly one result with the signed frequency change,
// the accumulated 32-bit frequency, a changed flag and the fast-mode flag. A poll is taken
// every cycle unless the poll channel stalls. After acceptance it sits in the input
// register, and the combinational knob update (phase decode, fast-step timing, gain
// multiply and accumulate) loads the output register once that register is free or being
// emptied. Throughput is one poll per cycle while the result channel does not stall; the
// knob state feedback closes within the update. The output register lets a new poll be
// taken while an earlier result still waits; with both registers full and the result
// stalled, the poll channel stalls. Configuration writes are taken at once (ready is
// always high) and must only be made while the unit is idle.
module polled_quadrature_tuning_knob_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // poll channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_phase_a,
    input  logic                                  i_phase_b,
    input  logic [pqtk_pkg::TIMER_W-1:0]          i_timer_now,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [pqtk_pkg::DELTA_W-1:0]   o_freq_delta,
    output logic [pqtk_pkg::FREQ_W-1:0]           o_frequency,
    output logic                                  o_freq_changed,
    output logic                                  o_fast_mode,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pqtk_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pqtk_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import pqtk_pkg::*;

    t_cfg    cfg;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result core_result;
    t_result r_out;
    logic    r_out_valid;
    logic    out_free, advance, in_xfer;

    assign o_cfg_ready = 1'b1;

    pqtk_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // handshake: the poll moves on when the output register is free or being emptied
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_xfer  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item.phase_a   <= i_phase_a;
            r_in_item.phase_b   <= i_phase_b;
            r_in_item.timer_now <= i_timer_now;
        end
    end

    pqtk_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_freq_delta   = r_out.freq_delta;
    assign o_frequency    = r_out.frequency;
    assign o_freq_changed = r_out.freq_changed;
    assign o_fast_mode    = r_out.fast_mode;

endmodule

[bench/tb_polled_quadrature_tuning_knob_unit.sv]
module tb_polled_quadrature_tuning_knob_unit;
    import pqtk_pkg::*;

    // no-transfer cycles before the run is declared hung
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned ITEMS_PER_PHASE = 180;
    localparam int unsigned NUM_PHASES      = 8;

    typedef enum logic {ROW_POLL, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        t_item                   item;
        logic                    typed;
        t_result                 exp;
    } t_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_phase_a;
    logic                        i_phase_b;
    logic [TIMER_W-1:0]          i_timer_now;
    logic                        o_valid;
    logic                        i_stall;
    logic signed [DELTA_W-1:0]   o_freq_delta;
    logic [FREQ_W-1:0]           o_frequency;
    logic                        o_freq_changed;
    logic                        o_fast_mode;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata;

    polled_quadrature_tuning_knob_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_phase_a      (i_phase_a),
        .i_phase_b      (i_phase_b),
        .i_timer_now    (i_timer_now),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_freq_delta   (o_freq_delta),
        .o_frequency    (o_frequency),
        .o_freq_changed (o_freq_changed),
        .o_fast_mode    (o_fast_mode),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // knob model state and register shadow
    t_cfg               knob_cfg;
    logic               knob_prev_a;
    logic               knob_prev_b;
    logic [TIMER_W-1:0] knob_last_time;
    logic [7:0]         knob_fast_count;
    logic [DIR_W-1:0]   knob_last_dir;
    logic               knob_fast_flag;
    logic               knob_rev_pending;
    logic [FREQ_W-1:0]  knob_freq;

    t_result            knob_expect_q[$];
    t_row               poll_table[$];
    int unsigned        err_count;

    // stimulus shaping state
    logic [TIMER_W-1:0] poll_timer;
    logic               spin_fast;
    logic               spin_up;
    logic               sender_calm;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic knob_reset();
        knob_cfg.step_size        = RST_STEP_SIZE;
        knob_cfg.fast_threshold   = RST_FAST_THRESHOLD;
        knob_cfg.fast_trigger     = RST_FAST_TRIGGER;
        knob_cfg.fast_gain        = RST_FAST_GAIN;
        knob_cfg.reverse_dir      = 1'b0;
        knob_cfg.accel_enable     = 1'b1;
        knob_cfg.dir_sense_enable = 1'b1;
        knob_prev_a      = 1'b0;
        knob_prev_b      = 1'b0;
        knob_last_time   = '0;
        knob_fast_count  = '0;
        knob_last_dir    = DIR_NONE;
        knob_fast_flag   = 1'b0;
        knob_rev_pending = 1'b0;
        knob_freq        = '0;
    endtask

    // register write, masked to each register's width
    task automatic knob_cfg_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_STEP_SIZE:      knob_cfg.step_size        = data[STEP_SIZE_W-1:0];
            REG_FAST_THRESHOLD: knob_cfg.fast_threshold   = data[TIMER_W-1:0];
            REG_FAST_TRIGGER:   knob_cfg.fast_trigger     = data[TRIGGER_W-1:0];
            REG_FAST_GAIN:      knob_cfg.fast_gain        = data[GAIN_W-1:0];
            REG_REVERSE_DIR:    knob_cfg.reverse_dir      = data[0];
            REG_ACCEL_ENABLE:   knob_cfg.accel_enable     = data[0];
            REG_DIR_SENSE:      knob_cfg.dir_sense_enable = data[0];
            default: ;
        endcase
    endtask

    // one poll: decode, fast-step timing, gain and accumulate
    function automatic t_result knob_predict(input t_item it);
        t_result          res;
        logic             stepped;
        logic             up;
        logic             neg;
        logic [DIR_W-1:0] dcode;
        logic [31:0]      mult;
        logic [31:0]      mag;
        logic [31:0]      delta;
        stepped = 1'b0;
        up      = 1'b0;
        delta   = '0;
        if (it.phase_a != knob_prev_a && it.phase_b != knob_prev_b) begin
            stepped = 1'b0;
        end else if (it.phase_a != knob_prev_a) begin
            knob_prev_a = it.phase_a;
            up          = (knob_prev_a != knob_prev_b);
            stepped     = 1'b1;
        end else if (it.phase_b != knob_prev_b) begin
            knob_prev_b = it.phase_b;
            up          = (knob_prev_a == knob_prev_b);
            stepped     = 1'b1;
        end
        if (stepped) begin
            mult = 32'd1;
            if (knob_cfg.accel_enable) begin
                dcode = up ? DIR_UP : DIR_DOWN;
                // rollover keeps the count
                if (knob_last_time > it.timer_now) begin
                end else if (TIMER_W'(it.timer_now - knob_last_time)
                             <= knob_cfg.fast_threshold) begin
                    if (knob_fast_count != COUNT_MAX)
                        knob_fast_count = knob_fast_count + 8'd1;
                end else begin
                    knob_fast_count = '0;
                end
                knob_last_time = it.timer_now;
                if (knob_fast_count > knob_cfg.fast_trigger)
                    knob_fast_flag = 1'b1;
                if (knob_cfg.dir_sense_enable) begin
                    if (knob_last_dir != dcode) begin
                        knob_rev_pending = ~knob_rev_pending;
                    end else if (knob_rev_pending) begin
                        knob_fast_flag   = 1'b0;
                        knob_rev_pending = 1'b0;
                    end
                    knob_last_dir = dcode;
                end
                if (knob_fast_flag)
                    mult = {25'd0, knob_cfg.fast_gain};
            end
            mag   = mult * {18'd0, knob_cfg.step_size};
            neg   = up ? knob_cfg.reverse_dir : ~knob_cfg.reverse_dir;
            delta = neg ? (32'd0 - mag) : mag;
            knob_freq = knob_freq + delta;
        end
        res.freq_delta   = delta[DELTA_W-1:0];
        res.frequency    = knob_freq;
        res.freq_changed = stepped;
        res.fast_mode    = knob_fast_flag & knob_cfg.accel_enable;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 50)
            $display("%0t mismatch: %s", $time, msg);
        err_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // poll transfer; the model runs at the edge that takes it
    task automatic send_poll(input t_item it, input logic typed, input t_result typed_exp);
        t_result     pred;
        int unsigned gap;
        i_valid     <= 1'b1;
        i_phase_a   <= it.phase_a;
        i_phase_b   <= it.phase_b;
        i_timer_now <= it.timer_now;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        pred = knob_predict(it);
        if (typed)
            knob_expect_q.push_back(typed_exp);
        else
            knob_expect_q.push_back(pred);
        gap = sender_calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold polls until every result is back, then let the pipe empty
    task automatic wait_results_settled();
        i_valid <= 1'b0;
        while (knob_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no low step
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        knob_cfg_write(idx, data);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] trig, input logic [CFG_DATA_W-1:0] gain,
                              input logic [CFG_DATA_W-1:0] rev, input logic [CFG_DATA_W-1:0] accel,
                              input logic [CFG_DATA_W-1:0] dsense);
        wait_results_settled();
        cfg_put(REG_STEP_SIZE, step);
        cfg_put(REG_FAST_THRESHOLD, thr);
        cfg_put(REG_FAST_TRIGGER, trig);
        cfg_put(REG_FAST_GAIN, gain);
        cfg_put(REG_REVERSE_DIR, rev);
        cfg_put(REG_ACCEL_ENABLE, accel);
        cfg_put(REG_DIR_SENSE, dsense);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_poll(input logic a, input logic b, input logic [TIMER_W-1:0] t,
                            input logic typed, input int d, input logic [FREQ_W-1:0] f,
                            input logic c, input logic m);
        t_row row;
        row                  = '0;
        row.kind             = ROW_POLL;
        row.item.phase_a     = a;
        row.item.phase_b     = b;
        row.item.timer_now   = t;
        row.typed            = typed;
        row.exp.freq_delta   = DELTA_W'(d);
        row.exp.frequency    = f;
        row.exp.freq_changed = c;
        row.exp.fast_mode    = m;
        poll_table.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_row row;
        row      = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = data;
        poll_table.push_back(row);
    endtask

    // mostly clean gray-code turns with sticky speed and direction, some holds and noise
    task automatic make_poll(output t_item it);
        int unsigned pick;
        logic        go_up;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 29) == 0)
            spin_fast = ~spin_fast;
        if ($urandom_range(0, 24) == 0)
            spin_up = ~spin_up;
        if ($urandom_range(0, 19) == 0)
            poll_timer = TIMER_W'($urandom_range(0, 16'hFFFF));
        else if (spin_fast)
            poll_timer = TIMER_W'(poll_timer
                                  + $urandom_range(0, knob_cfg.fast_threshold >> 1));
        else
            poll_timer = TIMER_W'(poll_timer + knob_cfg.fast_threshold
                                  + $urandom_range(1, 3000));
        it.timer_now = poll_timer;
        it.phase_a   = knob_prev_a;
        it.phase_b   = knob_prev_b;
        if (pick < 78) begin
            go_up = spin_up;
            if ($urandom_range(0, 39) == 0)
                go_up = ~go_up;
            if ((knob_prev_a == knob_prev_b) == go_up)
                it.phase_a = ~knob_prev_a;
            else
                it.phase_b = ~knob_prev_b;
        end else if (pick >= 96) begin
            it.phase_a = 1'($urandom_range(0, 1));
            it.phase_b = 1'($urandom_range(0, 1));
        end else if (pick >= 92) begin
            it.phase_a = ~knob_prev_a;
            it.phase_b = ~knob_prev_b;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (knob_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = knob_expect_q.pop_front();
                if (o_freq_delta !== want.freq_delta)
                    report_mismatch($sformatf("freq_delta got %0d want %0d",
                                              o_freq_delta, want.freq_delta));
                if (o_frequency !== want.frequency)
                    report_mismatch($sformatf("frequency got %0d want %0d",
                                              o_frequency, want.frequency));
                if (o_freq_changed !== want.freq_changed)
                    report_mismatch($sformatf("freq_changed got %b want %b",
                                              o_freq_changed, want.freq_changed));
                if (o_fast_mode !== want.fast_mode)
                    report_mismatch($sformatf("fast_mode got %b want %b",
                                              o_fast_mode, want.fast_mode));
            end
        end
    end

    // result-side backpressure: short stalls, a few long ones, stall-free stretches
    initial begin : stall_driver
        int unsigned span;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            span = pick_gap();
            if (span != 0) begin
                i_stall <= 1'b1;
                repeat (span) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            if ($urandom_range(0, 14) == 0)
                repeat ($urandom_range(60, 150)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // hang detector: cycles with no transfer on any channel
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0) ||
                (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_polled_quadrature_tuning_knob_unit: FAIL");
        $finish;
    end

    initial begin : main_seq
        t_item       it;
        int unsigned ph;
        int unsigned n;
        err_count   = 0;
        poll_timer  = '0;
        spin_fast   = 1'b1;
        spin_up     = 1'b1;
        sender_calm = 1'b0;
        knob_reset();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_phase_a   <= 1'b0;
        i_phase_b   <= 1'b0;
        i_timer_now <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_STEP_SIZE;
        i_cfg_wdata <= '0;

        // directed rows, starting from reset state and reset registers
        add_poll(1'b0, 1'b0, 16'd0,     1'b1, 0, 32'd0, 1'b0, 1'b0);     // no change
        add_poll(1'b1, 1'b1, 16'd5,     1'b1, 0, 32'd0, 1'b0, 1'b0);     // both changed
        add_poll(1'b1, 1'b0, 16'd100,   1'b1, 8388, 32'd8388, 1'b1, 1'b0);
        add_poll(1'b1, 1'b1, 16'd200,   1'b0, 0, 32'd0, 1'b0, 1'b0);     // B edge, up
        add_poll(1'b0, 1'b1, 16'd300,   1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b0, 1'b0, 16'd400,   1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b0, 1'b0, 16'd450,   1'b0, 0, 32'd0, 1'b0, 1'b0);     // hold
        add_poll(1'b1, 1'b0, 16'd500,   1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b1, 1'b1, 16'd600,   1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b0, 1'b1, 16'd700,   1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b0, 1'b0, 16'd800,   1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b1, 1'b0, 16'd900,   1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b1, 1'b1, 16'd1000,  1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b0, 1'b1, 16'd1100,  1'b0, 0, 32'd0, 1'b0, 1'b0);     // count passes trigger
        add_poll(1'b0, 1'b0, 16'd9000,  1'b0, 0, 32'd0, 1'b0, 1'b0);     // slow step
        add_poll(1'b0, 1'b1, 16'd9100,  1'b0, 0, 32'd0, 1'b0, 1'b0);     // reversal seen
        add_poll(1'b1, 1'b1, 16'd9200,  1'b0, 0, 32'd0, 1'b0, 1'b0);     // reversal confirmed
        add_poll(1'b1, 1'b0, 16'd65535, 1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b0, 1'b0, 16'd3,     1'b0, 0, 32'd0, 1'b0, 1'b0);     // timer rollover
        add_reg(REG_FAST_GAIN, 16'h0080);                                 // masks to zero gain
        add_reg(REG_FAST_TRIGGER, 16'h0000);
        add_poll(1'b0, 1'b1, 16'd10,    1'b0, 0, 32'd0, 1'b0, 1'b0);     // fast, zero delta
        add_reg(REG_ACCEL_ENABLE, 16'h0000);
        add_poll(1'b1, 1'b1, 16'd20,    1'b0, 0, 32'd0, 1'b0, 1'b0);     // accel off
        add_reg(REG_REVERSE_DIR, 16'h0001);
        add_reg(REG_STEP_SIZE, 16'hFFFF);                                 // wide step size
        add_poll(1'b1, 1'b0, 16'd30,    1'b0, 0, 32'd0, 1'b0, 1'b0);
        add_poll(1'b0, 1'b0, 16'd65535, 1'b0, 0, 32'd0, 1'b0, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < poll_table.size(); n++) begin
            if (poll_table[n].kind == ROW_REG) begin
                wait_results_settled();
                cfg_put(poll_table[n].idx, poll_table[n].data);
                i_cfg_valid <= 1'b0;
            end else begin
                send_poll(poll_table[n].item, poll_table[n].typed, poll_table[n].exp);
            end
        end

        // random phases over register settings, extremes first
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0001,
                              16'h0001);
                1: write_regs(16'h0000, 16'h0000, 16'h00FF, 16'h0000, 16'h0000, 16'h0001,
                              16'h0000);
                2: write_regs(16'd8388, 16'd3000, 16'd10, 16'd10, 16'h0000, 16'h0001,
                              16'h0001);
                3: write_regs(16'd8388, 16'd200, 16'd3, 16'd127, 16'h0001, 16'h0000,
                              16'h0001);
                4: write_regs(16'd1200, 16'd800, 16'd2, 16'h0080, 16'h0000, 16'h0001,
                              16'h0001);
                default: write_regs(CFG_DATA_W'($urandom_range(0, 16'hFFFF)),
                                    CFG_DATA_W'($urandom_range(0, 16'hFFFF)),
                                    CFG_DATA_W'($urandom_range(0, 20)),
                                    CFG_DATA_W'($urandom_range(0, 16'hFFFF)),
                                    CFG_DATA_W'($urandom_range(0, 16'hFFFF)),
                                    CFG_DATA_W'($urandom_range(0, 16'hFFFF)),
                                    CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                make_poll(it);
                send_poll(it, 1'b0, '0);
                if ($urandom_range(0, 149) == 0)
                    wait_results_settled();
                if ($urandom_range(0, 79) == 0)
                    sender_calm = ~sender_calm;
            end
        end

        wait_results_settled();
        repeat (4) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_polled_quadrature_tuning_knob_unit: PASS");
        else
            $display("tb_polled_quadrature_tuning_knob_unit: FAIL");
        $finish;
    end

endmodule
